FILE: src/rna_pkg.sv
// Shared types and constants for the rational number ALU.
// Holds opcodes, error codes, the controller/datapath command and status types
// and the microcode table that the controller steps through. No dependencies.
package rna_pkg;

    localparam int FUNC_W = 4;
    localparam int ERR_W  = 2;
    localparam int PC_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_MAKE         = 4'd0,
        FN_ADD          = 4'd1,
        FN_SUB          = 4'd2,
        FN_MUL          = 4'd3,
        FN_DIV          = 4'd4,
        FN_NEG          = 4'd5,
        FN_INV          = 4'd6,
        FN_FROM_INT     = 4'd7,
        FN_CEIL         = 4'd8,
        FN_CEIL_STRICT  = 4'd9,
        FN_FLOOR        = 4'd10,
        FN_FLOOR_STRICT = 4'd11
    } func_t;

    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ZERO_DEN = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd2;
    localparam logic [ERR_W-1:0] ERR_OVF      = 2'd3;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CHECK,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_GCD_UPD,
        OP_DIV,
        OP_WQ,
        OP_MUL,
        OP_WP,
        OP_COMB,
        OP_FIN
    } dp_op_t;

    // Datapath register names used as operand sources and destinations
    typedef enum logic [3:0] {
        SRC_NA,
        SRC_DA,
        SRC_NB,
        SRC_DB,
        SRC_GY,
        SRC_T1,
        SRC_T2,
        SRC_M1,
        SRC_M2,
        SRC_DEN
    } src_t;

    // Overflow limit for a product: positive range, or by the sign of a, b, a*b
    typedef enum logic [1:0] {
        LIM_POS,
        LIM_SA,
        LIM_SB,
        LIM_SX
    } lim_t;

    typedef enum logic [2:0] {
        UK_GCD,
        UK_DIV,
        UK_MUL,
        UK_COMB,
        UK_FIN_MAKE,
        UK_FIN_ADD,
        UK_FIN_MUL,
        UK_FIN_ROUND
    } uop_kind_t;

    typedef struct packed {
        uop_kind_t kind;
        src_t      a_sel;
        src_t      b_sel;
        src_t      dst;
        lim_t      lim;
    } uop_t;

    typedef struct packed {
        dp_op_t op;
        uop_t   uop;
    } cmd_t;

    typedef struct packed {
        logic            quick;
        logic [PC_W-1:0] start_pc;
        logic            gx_zero;
        logic            div_done;
        logic            mul_done;
    } dp_status_t;

    localparam logic [PC_W-1:0] PC_MAKE  = 5'd0;
    localparam logic [PC_W-1:0] PC_ADD   = 5'd4;
    localparam logic [PC_W-1:0] PC_MUL   = 5'd15;
    localparam logic [PC_W-1:0] PC_ROUND = 5'd24;

    function automatic uop_t ucode(logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // make: reduce by gcd(n, d)
            5'd0:  u = '{UK_GCD,       SRC_NA,  SRC_DA, SRC_T1,  LIM_POS};
            5'd1:  u = '{UK_DIV,       SRC_NA,  SRC_GY, SRC_T1,  LIM_POS};
            5'd2:  u = '{UK_DIV,       SRC_DA,  SRC_GY, SRC_T2,  LIM_POS};
            5'd3:  u = '{UK_FIN_MAKE,  SRC_NA,  SRC_DA, SRC_T1,  LIM_POS};
            // add / sub over the reduced common denominator
            5'd4:  u = '{UK_GCD,       SRC_DA,  SRC_DB, SRC_T1,  LIM_POS};
            5'd5:  u = '{UK_DIV,       SRC_DB,  SRC_GY, SRC_T1,  LIM_POS};
            5'd6:  u = '{UK_DIV,       SRC_DA,  SRC_GY, SRC_T2,  LIM_POS};
            5'd7:  u = '{UK_MUL,       SRC_T2,  SRC_DB, SRC_DEN, LIM_POS};
            5'd8:  u = '{UK_MUL,       SRC_NA,  SRC_T1, SRC_M1,  LIM_SA};
            5'd9:  u = '{UK_MUL,       SRC_NB,  SRC_T2, SRC_M2,  LIM_SB};
            5'd10: u = '{UK_COMB,      SRC_M1,  SRC_M2, SRC_M1,  LIM_POS};
            5'd11: u = '{UK_GCD,       SRC_M1,  SRC_DEN, SRC_T1, LIM_POS};
            5'd12: u = '{UK_DIV,       SRC_M1,  SRC_GY, SRC_T1,  LIM_POS};
            5'd13: u = '{UK_DIV,       SRC_DEN, SRC_GY, SRC_T2,  LIM_POS};
            5'd14: u = '{UK_FIN_ADD,   SRC_T1,  SRC_T2, SRC_T1,  LIM_POS};
            // mul / div with cross cancellation
            5'd15: u = '{UK_GCD,       SRC_NA,  SRC_DB, SRC_T1,  LIM_POS};
            5'd16: u = '{UK_DIV,       SRC_NA,  SRC_GY, SRC_T1,  LIM_POS};
            5'd17: u = '{UK_DIV,       SRC_DB,  SRC_GY, SRC_T2,  LIM_POS};
            5'd18: u = '{UK_GCD,       SRC_NB,  SRC_DA, SRC_T1,  LIM_POS};
            5'd19: u = '{UK_DIV,       SRC_NB,  SRC_GY, SRC_M1,  LIM_POS};
            5'd20: u = '{UK_DIV,       SRC_DA,  SRC_GY, SRC_M2,  LIM_POS};
            5'd21: u = '{UK_MUL,       SRC_T1,  SRC_M1, SRC_M1,  LIM_SX};
            5'd22: u = '{UK_MUL,       SRC_M2,  SRC_T2, SRC_DEN, LIM_POS};
            5'd23: u = '{UK_FIN_MUL,   SRC_M1,  SRC_DEN, SRC_M1, LIM_POS};
            // rounding
            5'd24: u = '{UK_DIV,       SRC_NA,  SRC_DA, SRC_T1,  LIM_POS};
            default: u = '{UK_FIN_ROUND, SRC_T1, SRC_T2, SRC_T1, LIM_POS};
        endcase
        return u;
    endfunction

endpackage

FILE: src/rational_number_alu.sv
// Rational number ALU: one word in, one word out, no state between words.
// from_int, neg, inv, undefined opcodes and errors found up front are answered
// from the check state; the other operations are microcoded on the shared serial
// divider (one division per Euclid step) and multiplier: make = gcd + 2 div,
// add/sub = 2 gcd + 4 div + 3 mul, mul/div = 2 gcd + 4 div + 2 mul, rounding =
// 1 div. One word at a time; the next is taken at return to idle.
// Reset (rst_n, async, active low) idles the sequencer and drops any result.
module rational_number_alu
    import rna_pkg::*;
#(
    parameter int INT_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // lsb up: func[3:0], a_num, a_den, b_num, b_den (INT_WIDTH each), zero pad
    input  logic [((FUNC_W + 4*INT_WIDTH + 7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // lsb up: res_num, res_den (INT_WIDTH each), error_code[1:0], zero pad
    output logic [((2*INT_WIDTH + ERR_W + 7)/8)*8-1:0]  m_tdata
);
    localparam int W        = INT_WIDTH;
    localparam int OUT_W    = 2 * INT_WIDTH + ERR_W;
    localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

    cmd_t             cmd;
    dp_status_t       st;
    logic [W-1:0]     res_num, res_den;
    logic [ERR_W-1:0] error_code;

    // sequencer: handshakes plus microcode stepping
    rna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: operands, gcd loop registers, divider, multiplier, result
    rna_dp #(.W(W)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (s_tdata[FUNC_W-1:0]),
        .a_num      (s_tdata[FUNC_W +: W]),
        .a_den      (s_tdata[FUNC_W + W +: W]),
        .b_num      (s_tdata[FUNC_W + 2*W +: W]),
        .b_den      (s_tdata[FUNC_W + 3*W +: W]),
        .st         (st),
        .res_num    (res_num),
        .res_den    (res_den),
        .error_code (error_code)
    );

    // pack the result word, zero fill to whole bytes
    assign m_tdata = OUT_TD_W'({error_code, res_den, res_num});

endmodule

FILE: src/rna_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses no package; instantiated by rna_dp.
module rna_div #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quot,
    output logic [W-1:0] remd,
    output logic         done
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dvs_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= fits ? diff[W-1:0] : shifted[W-1:0];
        end
    end

    assign quot = quo_reg;
    assign remd = rem_reg;
    assign done = done_reg;

endmodule

FILE: src/rna_mul.sv
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Uses no package; instantiated by rna_dp.
module rna_mul #(
    parameter int W = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] prod,
    output logic           done
);
    localparam int CW = $clog2(W + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic [2*W-1:0] acc_reg;
    logic [2*W-1:0] mcand_reg;
    logic [W-1:0]   mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            acc_reg    <= '0;
            mcand_reg  <= (2*W)'(a);
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[2*W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[W-1:1]};
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

FILE: src/rna_dp.sv
// Datapath of the rational ALU: operand registers, gcd registers, temporaries,
// the shared divider and multiplier, and the result register.
// Depends on rna_pkg, rna_div and rna_mul; driven by commands from rna_ctrl.
module rna_dp
    import rna_pkg::*;
#(
    parameter int W = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic [FUNC_W-1:0] func,
    input  logic [W-1:0]      a_num,
    input  logic [W-1:0]      a_den,
    input  logic [W-1:0]      b_num,
    input  logic [W-1:0]      b_den,
    output dp_status_t        st,
    output logic [W-1:0]      res_num,
    output logic [W-1:0]      res_den,
    output logic [ERR_W-1:0]  error_code
);
    localparam logic [W-1:0] POSLIM = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] TOPBIT = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE    = W'(1);

    logic [FUNC_W-1:0] func_reg;
    logic [W-1:0]      na_reg, da_reg, nb_reg, db_reg;
    logic              sa_reg, sb_reg, aneg_reg, sres_reg, ovf_reg;
    logic [W-1:0]      gx_reg, gy_reg, t1_reg, t2_reg, m1_reg, m2_reg, den_reg;
    logic [W-1:0]      res_num_reg, res_den_reg;
    logic [ERR_W-1:0]  err_reg;

    logic [W-1:0]   a_val, b_val;
    logic [W-1:0]   div_quot, div_rem;
    logic           div_done, mul_done;
    logic [2*W-1:0] mul_prod;
    logic [W-1:0]   lim_val;

    logic [W-1:0] in_na, in_da, in_nb, in_db;
    logic         in_sb;

    logic            q_quick, q_swap;
    logic [PC_W-1:0] q_pc;

    logic             e_wr, e_neg;
    logic [W-1:0]     e_n, e_d;
    logic [ERR_W-1:0] e_err;

    logic         c_sa, c_sb;
    logic [W-1:0] c_m;
    logic         c_s, c_ovf;

    function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
        return v[W-1] ? (~v + ONE) : v;
    endfunction

    function automatic logic [W-1:0] lim_of(logic neg);
        return neg ? TOPBIT : POSLIM;
    endfunction

    // operand selection
    always_comb
    begin
        case (cmd.uop.a_sel)
            SRC_NA:  a_val = na_reg;
            SRC_DA:  a_val = da_reg;
            SRC_NB:  a_val = nb_reg;
            SRC_DB:  a_val = db_reg;
            SRC_GY:  a_val = gy_reg;
            SRC_T1:  a_val = t1_reg;
            SRC_T2:  a_val = t2_reg;
            SRC_M1:  a_val = m1_reg;
            SRC_M2:  a_val = m2_reg;
            SRC_DEN: a_val = den_reg;
            default: a_val = '0;
        endcase
        case (cmd.uop.b_sel)
            SRC_NA:  b_val = na_reg;
            SRC_DA:  b_val = da_reg;
            SRC_NB:  b_val = nb_reg;
            SRC_DB:  b_val = db_reg;
            SRC_GY:  b_val = gy_reg;
            SRC_T1:  b_val = t1_reg;
            SRC_T2:  b_val = t2_reg;
            SRC_M1:  b_val = m1_reg;
            SRC_M2:  b_val = m2_reg;
            SRC_DEN: b_val = den_reg;
            default: b_val = '0;
        endcase
        case (cmd.uop.lim)
            LIM_SA:  lim_val = lim_of(sa_reg);
            LIM_SB:  lim_val = lim_of(sb_reg);
            LIM_SX:  lim_val = lim_of(sa_reg ^ sb_reg);
            default: lim_val = POSLIM;
        endcase
    end

    rna_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_DIV || cmd.op == OP_GCD_STEP),
        .dividend (cmd.op == OP_GCD_STEP ? gy_reg : a_val),
        .divisor  (cmd.op == OP_GCD_STEP ? gx_reg : b_val),
        .quot     (div_quot),
        .remd     (div_rem),
        .done     (div_done)
    );

    rna_mul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_MUL),
        .a     (a_val),
        .b     (b_val),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    // operand magnitudes at load time
    assign in_na = mag_of(a_num);
    assign in_da = mag_of(a_den);
    assign in_nb = mag_of(b_num);
    assign in_db = mag_of(b_den);
    // subtract flips the sign of b
    assign in_sb = (func == FN_SUB)
                 ? (!((b_num[W-1] ^ b_den[W-1]) && in_nb != '0) && in_nb != '0)
                 : ((b_num[W-1] ^ b_den[W-1]) && in_nb != '0);

    // quick decisions: errors, unary ops and the program entry point
    always_comb
    begin : quick_dec
        logic s;
        s       = !sa_reg && na_reg != '0;
        q_quick = 1'b1;
        q_swap  = 1'b0;
        q_pc    = PC_MAKE;
        e_neg   = 1'b0;
        e_n     = '0;
        e_d     = '0;
        e_err   = ERR_OK;
        if (func_reg == FN_FROM_INT)
        begin
            e_neg = aneg_reg;
            e_n   = na_reg;
            e_d   = ONE;
        end
        else if (func_reg > FN_FLOOR_STRICT)
        begin
            e_d = ONE;
        end
        else if (da_reg == '0)
        begin
            e_err = ERR_ZERO_DEN;
        end
        else if (func_reg >= FN_ADD && func_reg <= FN_DIV && db_reg == '0)
        begin
            e_err = ERR_ZERO_DEN;
        end
        else
        begin
            case (func_reg)
                FN_MAKE:
                begin
                    q_quick = 1'b0;
                    q_pc    = PC_MAKE;
                end
                FN_ADD, FN_SUB:
                begin
                    q_quick = 1'b0;
                    q_pc    = PC_ADD;
                end
                FN_MUL:
                begin
                    q_quick = 1'b0;
                    q_pc    = PC_MUL;
                end
                FN_DIV:
                begin
                    if (nb_reg == '0)
                    begin
                        e_err = ERR_DIV_ZERO;
                    end
                    else if (nb_reg > POSLIM || db_reg > lim_of(sb_reg))
                    begin
                        e_err = ERR_OVF;
                    end
                    else
                    begin
                        q_quick = 1'b0;
                        q_pc    = PC_MUL;
                        q_swap  = 1'b1;
                    end
                end
                FN_NEG:
                begin
                    if (na_reg > lim_of(s) || da_reg > POSLIM)
                    begin
                        e_err = ERR_OVF;
                    end
                    else
                    begin
                        e_neg = s;
                        e_n   = na_reg;
                        e_d   = da_reg;
                    end
                end
                FN_INV:
                begin
                    if (na_reg == '0)
                    begin
                        e_err = ERR_DIV_ZERO;
                    end
                    else if (na_reg > POSLIM || da_reg > lim_of(sa_reg))
                    begin
                        e_err = ERR_OVF;
                    end
                    else
                    begin
                        e_neg = sa_reg;
                        e_n   = da_reg;
                        e_d   = na_reg;
                    end
                end
                default:
                begin
                    q_quick = 1'b0;
                    q_pc    = PC_ROUND;
                end
            endcase
        end
    end

    // final result of a microcoded program
    logic             f_neg;
    logic [W-1:0]     f_n, f_d;
    logic [ERR_W-1:0] f_err;

    always_comb
    begin : fin_sel
        logic [W-1:0] m;
        logic         s;
        logic         want_floor;
        m          = '0;
        s          = 1'b0;
        want_floor = (func_reg == FN_CEIL_STRICT) || (func_reg == FN_FLOOR);
        f_neg      = 1'b0;
        f_n        = t1_reg;
        f_d        = t2_reg;
        f_err      = ovf_reg ? ERR_OVF : ERR_OK;
        case (cmd.uop.kind)
            UK_FIN_MAKE:
            begin
                f_neg = sa_reg;
                f_err = (t1_reg > lim_of(sa_reg) || t2_reg > POSLIM) ? ERR_OVF : ERR_OK;
            end
            UK_FIN_ADD:
            begin
                f_neg = sres_reg && t1_reg != '0;
            end
            UK_FIN_MUL:
            begin
                f_neg = (sa_reg ^ sb_reg) && m1_reg != '0;
                f_n   = m1_reg;
                f_d   = den_reg;
            end
            default:
            begin
                // exact floor/ceil from the truncated quotient and remainder
                if (sa_reg == want_floor)
                begin
                    m = t1_reg + W'(div_rem != '0);
                end
                else
                begin
                    m = t1_reg;
                end
                s = sa_reg && m != '0;
                if (func_reg == FN_CEIL_STRICT)
                begin
                    if (s)
                    begin
                        m = m - ONE;
                        s = m != '0;
                    end
                    else
                    begin
                        m = m + ONE;
                    end
                end
                else if (func_reg == FN_FLOOR_STRICT)
                begin
                    if (s)
                    begin
                        m = m + ONE;
                    end
                    else if (m == '0)
                    begin
                        s = 1'b1;
                        m = ONE;
                    end
                    else
                    begin
                        m = m - ONE;
                    end
                end
                f_neg = s;
                f_n   = m;
                f_d   = ONE;
                f_err = (m > lim_of(s)) ? ERR_OVF : ERR_OK;
            end
        endcase
    end

    // sign-magnitude combine for add / sub
    always_comb
    begin
        c_sa  = sa_reg && m1_reg != '0;
        c_sb  = sb_reg && m2_reg != '0;
        c_ovf = 1'b0;
        if (c_sa == c_sb)
        begin
            c_m   = m1_reg + m2_reg;
            c_s   = c_sa;
            c_ovf = m2_reg > (lim_of(c_sa) - m1_reg);
        end
        else if (m1_reg >= m2_reg)
        begin
            c_m = m1_reg - m2_reg;
            c_s = c_sa;
        end
        else
        begin
            c_m = m2_reg - m1_reg;
            c_s = c_sb;
        end
    end

    assign e_wr = (cmd.op == OP_CHECK && q_quick) || cmd.op == OP_FIN;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                func_reg <= func;
                na_reg   <= in_na;
                da_reg   <= in_da;
                nb_reg   <= in_nb;
                db_reg   <= in_db;
                aneg_reg <= a_num[W-1];
                sa_reg   <= (a_num[W-1] ^ a_den[W-1]) && in_na != '0;
                sb_reg   <= in_sb;
                ovf_reg  <= 1'b0;
            end
            OP_CHECK:
            begin
                if (q_swap)
                begin
                    nb_reg <= db_reg;
                    db_reg <= nb_reg;
                end
            end
            OP_GCD_INIT:
            begin
                gx_reg <= a_val;
                gy_reg <= b_val;
            end
            OP_GCD_UPD:
            begin
                gy_reg <= gx_reg;
                gx_reg <= div_rem;
            end
            OP_WQ, OP_WP:
            begin
                if (cmd.op == OP_WP)
                begin
                    ovf_reg <= ovf_reg || mul_prod[2*W-1:W] != '0
                            || mul_prod[W-1:0] > lim_val;
                end
                case (cmd.uop.dst)
                    SRC_T1:  t1_reg  <= (cmd.op == OP_WQ) ? div_quot : mul_prod[W-1:0];
                    SRC_T2:  t2_reg  <= (cmd.op == OP_WQ) ? div_quot : mul_prod[W-1:0];
                    SRC_M1:  m1_reg  <= (cmd.op == OP_WQ) ? div_quot : mul_prod[W-1:0];
                    SRC_M2:  m2_reg  <= (cmd.op == OP_WQ) ? div_quot : mul_prod[W-1:0];
                    SRC_DEN: den_reg <= (cmd.op == OP_WQ) ? div_quot : mul_prod[W-1:0];
                    default: ;
                endcase
            end
            OP_COMB:
            begin
                m1_reg   <= c_m;
                sres_reg <= c_s;
                ovf_reg  <= ovf_reg || c_ovf;
            end
            default: ;
        endcase

        if (e_wr)
        begin
            if (cmd.op == OP_FIN)
            begin
                res_num_reg <= (f_err != ERR_OK) ? '0 : (f_neg ? (~f_n + ONE) : f_n);
                res_den_reg <= (f_err != ERR_OK) ? '0 : f_d;
                err_reg     <= f_err;
            end
            else
            begin
                res_num_reg <= (e_err != ERR_OK) ? '0 : (e_neg ? (~e_n + ONE) : e_n);
                res_den_reg <= (e_err != ERR_OK) ? '0 : e_d;
                err_reg     <= e_err;
            end
        end
    end

    assign st.quick    = q_quick;
    assign st.start_pc = q_pc;
    assign st.gx_zero  = gx_reg == '0;
    assign st.div_done = div_done;
    assign st.mul_done = mul_done;

    assign res_num    = res_num_reg;
    assign res_den    = res_den_reg;
    assign error_code = err_reg;

endmodule

FILE: src/rna_ctrl.sv
// Controller of the rational ALU: input/output handshakes and a microcode
// sequencer that drives rna_dp. Depends on rna_pkg.
module rna_ctrl
    import rna_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t st,
    output cmd_t       cmd
);
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CHECK    = 7'b0000010,
        S_RUN      = 7'b0000100,
        S_GCD_TEST = 7'b0001000,
        S_GCD_WAIT = 7'b0010000,
        S_DIV_WAIT = 7'b0100000,
        S_MUL_WAIT = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free, set_out;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        set_out    = 1'b0;
        cmd.op     = OP_NOP;
        cmd.uop    = ucode(pc_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!st.quick)
                begin
                    cmd.op     = OP_CHECK;
                    pc_next    = st.start_pc;
                    state_next = S_RUN;
                end
                else if (out_free)
                begin
                    cmd.op     = OP_CHECK;
                    set_out    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RUN:
            begin
                case (cmd.uop.kind)
                    UK_GCD:
                    begin
                        cmd.op     = OP_GCD_INIT;
                        state_next = S_GCD_TEST;
                    end
                    UK_DIV:
                    begin
                        cmd.op     = OP_DIV;
                        state_next = S_DIV_WAIT;
                    end
                    UK_MUL:
                    begin
                        cmd.op     = OP_MUL;
                        state_next = S_MUL_WAIT;
                    end
                    UK_COMB:
                    begin
                        cmd.op  = OP_COMB;
                        pc_next = pc_reg + 1'b1;
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            cmd.op     = OP_FIN;
                            set_out    = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_GCD_TEST:
            begin
                if (st.gx_zero)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_RUN;
                end
                else
                begin
                    cmd.op     = OP_GCD_STEP;
                    state_next = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_GCD_UPD;
                    state_next = S_GCD_TEST;
                end
            end
            S_DIV_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_WQ;
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_RUN;
                end
            end
            S_MUL_WAIT:
            begin
                if (st.mul_done)
                begin
                    cmd.op     = OP_WP;
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (set_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;

endmodule

FILE: src/rna_checker.sv
// Port-level checks for rational_number_alu, bound to the top level.
// Depends on rna_pkg for the error codes.
module rna_checker
    import rna_pkg::*;
#(
    parameter int INT_WIDTH = 64
) (
    input logic                                        clk,
    input logic                                        rst_n,
    input logic                                        s_tvalid,
    input logic                                        s_tready,
    input logic                                        m_tvalid,
    input logic                                        m_tready,
    input logic [((2*INT_WIDTH+ERR_W+7)/8)*8-1:0]      m_tdata
);
    localparam int W = INT_WIDTH;

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: input closes after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // error results carry a zero numerator and denominator
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2*W +: ERR_W] != ERR_OK
        |-> m_tdata[2*W-1:0] == '0)
        else $error("error result with nonzero payload");

    // good results have a positive denominator
    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2*W +: ERR_W] == ERR_OK
        |-> !m_tdata[2*W-1] && m_tdata[2*W-1:W] != '0)
        else $error("denominator not positive");

endmodule

bind rational_number_alu rna_checker #(.INT_WIDTH(INT_WIDTH)) u_rna_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
